>>> sv/tsq_pkg.sv
// Package for the two-stack queue: sequencer state type, status codes and
// payload widths. No dependencies; used by every module of the block.
package tsq_pkg;

  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  // Input command codes.
  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOVE,
    ST_POP,
    ST_POP_DATA,
    ST_DONE
  } state_e;

endpackage

>>> sv/tsq_ram.sv
// Stack storage for the two-stack queue: one write port and one read port
// with registered read data. Depends on tsq_pkg for the element width.
module tsq_ram #(
  parameter int DEPTH = 16
) (
  input  logic                              clk_i,
  input  logic                              we_i,
  input  logic [$clog2(DEPTH)-1:0]          waddr_i,
  input  logic signed [tsq_pkg::VALUE_W-1:0] wdata_i,
  input  logic [$clog2(DEPTH)-1:0]          raddr_i,
  output logic signed [tsq_pkg::VALUE_W-1:0] rdata_o
);
  import tsq_pkg::*;

  logic signed [VALUE_W-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> sv/two_stack_queue.sv
// Top level of the two-stack queue: sequencer, counters, output register.
// Depends on tsq_pkg and instantiates tsq_ram for the two stacks.
//
//  Channel | Direction | Handshake               | Fields
//  --------+-----------+-------------------------+---------------------
//  in      | input     | in_valid_i / in_stall_o | command_i, value_i
//  out     | output    | out_valid_o/out_stall_i | status_o, value_out_o
//
// An enqueue or a dequeue may first have to fill the outbound stack; the move copies the
// inbound elements one element per cycle through the single stack read port.
// The input is stalled while an item is in work. A finished result sits in the
// output register; the next item is accepted meanwhile, and its result waits in
// the sequencer until the output register frees. Reset clears both counts.
module two_stack_queue #(
  parameter int STACK_DEPTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                command_i,
  input  logic signed [tsq_pkg::VALUE_W-1:0]  value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [tsq_pkg::STATUS_W-1:0]        status_o,
  output logic signed [tsq_pkg::VALUE_W-1:0]  value_out_o
);
  import tsq_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

  state_e state_q, state_d;
  logic [CW-1:0] in_cnt_q, in_cnt_d;
  logic [CW-1:0] out_cnt_q, out_cnt_d;
  logic [CW-1:0] rk_q, rk_d;
  logic          wr_vld_q, wr_vld_d;
  logic [AW-1:0] wk_q, wk_d;
  logic          pend_cmd_q, pend_cmd_d;
  logic signed [VALUE_W-1:0] pend_val_q, pend_val_d;
  logic [STATUS_W-1:0]       res_status_q, res_status_d;
  logic signed [VALUE_W-1:0] res_value_q, res_value_d;
  logic                      out_valid_q, out_valid_d;
  logic [STATUS_W-1:0]       out_status_q, out_status_d;
  logic signed [VALUE_W-1:0] out_value_q, out_value_d;

  logic                      ib_we;
  logic [AW-1:0]             ib_waddr;
  logic signed [VALUE_W-1:0] ib_wdata;
  logic [AW-1:0]             ib_raddr;
  logic signed [VALUE_W-1:0] ib_rdata;
  logic                      ob_we;
  logic [AW-1:0]             ob_raddr;
  logic signed [VALUE_W-1:0] ob_rdata;

  logic [CW-1:0] rd_idx;
  logic [CW-1:0] pop_idx;
  logic          in_xfer;
  logic          out_free;

  // Inbound and outbound stack storage.
  tsq_ram #(.DEPTH(STACK_DEPTH)) u_ib_ram (
    .clk_i   (clk_i),
    .we_i    (ib_we),
    .waddr_i (ib_waddr),
    .wdata_i (ib_wdata),
    .raddr_i (ib_raddr),
    .rdata_o (ib_rdata)
  );

  tsq_ram #(.DEPTH(STACK_DEPTH)) u_ob_ram (
    .clk_i   (clk_i),
    .we_i    (ob_we),
    .waddr_i (wk_q),
    .wdata_i (ib_rdata),
    .raddr_i (ob_raddr),
    .rdata_o (ob_rdata)
  );

  // Handshake and address helpers.
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign rd_idx      = in_cnt_q - rk_q - CW'(1);
  assign pop_idx     = out_cnt_q - CW'(1);
  assign ib_raddr    = rd_idx[AW-1:0];
  assign ob_raddr    = pop_idx[AW-1:0];
  assign ob_we       = wr_vld_q;
  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign value_out_o = out_value_q;

  // Sequencer state and control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      in_cnt_q    <= '0;
      out_cnt_q   <= '0;
      rk_q        <= '0;
      wr_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      in_cnt_q    <= in_cnt_d;
      out_cnt_q   <= out_cnt_d;
      rk_q        <= rk_d;
      wr_vld_q    <= wr_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    wk_q         <= wk_d;
    pend_cmd_q   <= pend_cmd_d;
    pend_val_q   <= pend_val_d;
    res_status_q <= res_status_d;
    res_value_q  <= res_value_d;
    out_status_q <= out_status_d;
    out_value_q  <= out_value_d;
  end

  // Next state, stack accesses and result handling.
  always_comb begin
    state_d      = state_q;
    in_cnt_d     = in_cnt_q;
    out_cnt_d    = out_cnt_q;
    rk_d         = rk_q;
    wr_vld_d     = 1'b0;
    wk_d         = wk_q;
    pend_cmd_d   = pend_cmd_q;
    pend_val_d   = pend_val_q;
    res_status_d = res_status_q;
    res_value_d  = res_value_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_value_d  = out_value_q;
    ib_we        = 1'b0;
    ib_waddr     = in_cnt_q[AW-1:0];
    ib_wdata     = value_i;

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          pend_cmd_d   = command_i;
          pend_val_d   = value_i;
          res_status_d = STATUS_OK;
          res_value_d  = '0;
          rk_d         = '0;
          if (command_i == CMD_ENQ) begin
            // Push directly, reject, or move the full inbound stack first.
            priority if (in_cnt_q < DEPTH_C) begin
              ib_we    = 1'b1;
              in_cnt_d = in_cnt_q + CW'(1);
              state_d  = ST_DONE;
            end else if (out_cnt_q != '0) begin
              res_status_d = STATUS_FULL;
              state_d      = ST_DONE;
            end else begin
              state_d = ST_MOVE;
            end
          end else begin
            // Pop, report empty, or refill the outbound stack first.
            priority if (out_cnt_q != '0) begin
              out_cnt_d = pop_idx;
              state_d   = ST_POP_DATA;
            end else if (in_cnt_q == '0) begin
              res_status_d = STATUS_EMPTY;
              state_d      = ST_DONE;
            end else begin
              state_d = ST_MOVE;
            end
          end
        end
      end

      ST_MOVE: begin
        // Read inbound from the top down, write outbound from the bottom up.
        if (rk_q != in_cnt_q) begin
          wr_vld_d = 1'b1;
          wk_d     = rk_q[AW-1:0];
          rk_d     = rk_q + CW'(1);
        end else if (!wr_vld_q) begin
          out_cnt_d = in_cnt_q;
          in_cnt_d  = '0;
          if (pend_cmd_q == CMD_ENQ) begin
            ib_we    = 1'b1;
            ib_waddr = '0;
            ib_wdata = pend_val_q;
            in_cnt_d = CW'(1);
            state_d  = ST_DONE;
          end else begin
            state_d = ST_POP;
          end
        end
      end

      ST_POP: begin
        out_cnt_d = pop_idx;
        state_d   = ST_POP_DATA;
      end

      ST_POP_DATA: begin
        res_value_d = ob_rdata;
        state_d     = ST_DONE;
      end

      ST_DONE: begin
        // Hand the result over once the output register is free.
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_value_d  = res_value_q;
          state_d      = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the two-stack queue: directed corner cases, then
// random enqueue/dequeue traffic checked against a behavioral queue mirror.
// Depends on tsq_pkg and the two_stack_queue RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import tsq_pkg::*;

  localparam int DEPTH        = 16;
  localparam int BLOCK_ITEMS  = 50;
  localparam int RANDOM_ITEMS = 1050;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] value;
  } queue_result_t;

  // DUT ports; the inputs are driven from time zero.
  logic                       clk_i       = 1'b0;
  logic                       rst_ni      = 1'b0;
  logic                       in_valid_i  = 1'b0;
  logic                       command_i   = CMD_ENQ;
  logic signed [VALUE_W-1:0]  value_i     = '0;
  logic                       out_stall_i = 1'b0;
  logic                       in_stall_o;
  logic                       out_valid_o;
  logic [STATUS_W-1:0]        status_o;
  logic signed [VALUE_W-1:0]  value_out_o;

  // Mirror of the queue: two stacks and their fill levels.
  logic signed [VALUE_W-1:0] inbound_mirror [DEPTH];
  logic signed [VALUE_W-1:0] outbound_mirror [DEPTH];
  int                        inbound_level  = 0;
  int                        outbound_level = 0;

  // Results predicted but not yet seen on the output channel.
  queue_result_t pending_results [$];

  int errors     = 0;
  int n_enq      = 0;
  int n_deq      = 0;
  int n_full     = 0;
  int n_empty    = 0;
  int n_moves    = 0;
  int n_checked  = 0;
  bit no_idle    = 1'b0;

  always #5 clk_i = ~clk_i;

  two_stack_queue #(
    .STACK_DEPTH(DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .command_i  (command_i),
    .value_i    (value_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .status_o   (status_o),
    .value_out_o(value_out_o)
  );

  // Moving the inbound stack onto the empty outbound stack reverses the order,
  // so the oldest element ends up on top.
  function automatic void move_inbound_to_outbound();
    int k;
    for (k = 0; k < inbound_level; k++) begin
      outbound_mirror[k] = inbound_mirror[inbound_level-1-k];
    end
    outbound_level = inbound_level;
    inbound_level  = 0;
    n_moves++;
  endfunction

  // Applies one command to the mirror and returns the result it must produce.
  function automatic queue_result_t queue_step(logic cmd, logic signed [VALUE_W-1:0] val);
    queue_result_t r;
    r.status = STATUS_OK;
    r.value  = '0;
    if (cmd == CMD_ENQ) begin
      n_enq++;
      if (inbound_level == DEPTH) begin
        if (outbound_level != 0) begin
          r.status = STATUS_FULL;
        end else begin
          move_inbound_to_outbound();
        end
      end
      if (r.status == STATUS_OK) begin
        inbound_mirror[inbound_level] = val;
        inbound_level++;
      end else begin
        n_full++;
      end
    end else begin
      n_deq++;
      if (outbound_level == 0 && inbound_level != 0) begin
        move_inbound_to_outbound();
      end
      if (outbound_level == 0) begin
        r.status = STATUS_EMPTY;
        n_empty++;
      end else begin
        outbound_level--;
        r.value = outbound_mirror[outbound_level];
      end
    end
    return r;
  endfunction

  // Random element, with the extremes and all-zero/all-one patterns favored.
  function automatic logic signed [VALUE_W-1:0] random_element();
    case ($urandom_range(0, 7))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  // Sends one item after a random gap; called and returns at a falling edge.
  task automatic send_item(input logic cmd, input logic signed [VALUE_W-1:0] val);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    value_i    <= val;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(queue_step(cmd, val));
    @(negedge clk_i);
  endtask

  // Compares one accepted result with the oldest prediction.
  task automatic check_result();
    queue_result_t want;
    if (pending_results.size() == 0) begin
      errors++;
      $display("%0t: unexpected result, expected none, got status %0d value %0d",
               $time, status_o, value_out_o);
    end else begin
      want = pending_results.pop_front();
      n_checked++;
      if (status_o !== want.status) begin
        errors++;
        $display("%0t: status mismatch, expected %0d, got %0d", $time, want.status, status_o);
      end
      if (value_out_o !== want.value) begin
        errors++;
        $display("%0t: value mismatch, expected %0d, got %0d",
                 $time, want.value, value_out_o);
      end
    end
  endtask

  // Output side: stall for a random gap before each transfer, then check it.
  initial begin : result_monitor
    int hold;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      hold = no_idle ? 0 : $urandom_range(0, 4);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      check_result();
      @(negedge clk_i);
    end
  end

  // Dequeues on the empty queue, with the ignored value field set both ways.
  task automatic test_empty_dequeue();
    send_item(CMD_DEQ, '0);
    send_item(CMD_DEQ, '1);
  endtask

  // Extreme values pass through, and a dequeue refills from the inbound stack.
  task automatic test_value_extremes();
    send_item(CMD_ENQ, 32'sh8000_0000);
    send_item(CMD_ENQ, 32'sh7fff_ffff);
    send_item(CMD_DEQ, 32'sh1234_5678);
    send_item(CMD_DEQ, '0);
  endtask

  // Fill the inbound stack, then enqueue once more so it moves to the
  // empty outbound stack. Runs back to back with no idling.
  task automatic test_move_on_full();
    int i;
    no_idle = 1'b1;
    for (i = 0; i <= DEPTH; i++) begin
      send_item(CMD_ENQ, (i % 2 == 0) ? 32'sh5555_5555 ^ i : 32'shaaaa_aaaa ^ i);
    end
    no_idle = 1'b0;
  endtask

  // Blocks of fill-heavy, drain-heavy and balanced traffic. Filling blocks
  // hit the rejected-full case, draining ones the empty case.
  task automatic test_random_traffic();
    int blk;
    int i;
    int enq_pct;
    for (blk = 0; blk < RANDOM_ITEMS / BLOCK_ITEMS; blk++) begin
      case ($urandom_range(0, 2))
        0: enq_pct = 85;
        1: enq_pct = 15;
        default: enq_pct = 50;
      endcase
      no_idle = ($urandom_range(0, 3) == 0);
      for (i = 0; i < BLOCK_ITEMS; i++) begin
        send_item(($urandom_range(1, 100) <= enq_pct) ? CMD_ENQ : CMD_DEQ, random_element());
      end
    end
    no_idle = 1'b0;
  endtask

  // Reset, the test sequence, then drain and report.
  initial begin : main_sequence
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_empty_dequeue();
    test_value_extremes();
    test_move_on_full();
    test_random_traffic();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    $display("Covered %0d enqueues (%0d rejected full) and %0d dequeues (%0d on empty),",
             n_enq, n_full, n_deq, n_empty);
    $display("with %0d stack moves; %0d results checked, %0d mismatches.",
             n_moves, n_checked, errors);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin : watchdog
    #2_000_000;
    $display("Timeout with %0d results still pending.", pending_results.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
